// ----- rtl/fnq_pkg.sv -----
`timescale 1ns / 1ps

package fnq_pkg;

    localparam int unsigned FREQ_W    = 16;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned NOTE_W    = 3;
    localparam int unsigned OCTAVE_W  = 3;
    localparam int unsigned SNAP_W    = 12;
    localparam int unsigned NOTES     = 7;

    localparam logic [FREQ_W-1:0]   BASE_FREQ  = 16'd4186;
    localparam logic [OCTAVE_W-1:0] TOP_OCTAVE = 3'd7;

    typedef enum logic [STATUS_W-1:0] {
        ST_IN_RANGE = 2'd0,
        ST_TOO_LOW  = 2'd1,
        ST_TOO_HIGH = 2'd2
    } status_t;

    typedef struct packed {
        status_t               status;
        logic [NOTE_W-1:0]     note;
        logic [OCTAVE_W-1:0]   octave;
        logic [SNAP_W-1:0]     snapped;
    } result_t;

    function automatic logic [FREQ_W-1:0] note_freq(input logic [NOTE_W-1:0] idx);
        logic [FREQ_W-1:0] val;
        case (idx)
            3'd0:    val = 16'd4186;
            3'd1:    val = 16'd4699;
            3'd2:    val = 16'd5274;
            3'd3:    val = 16'd5588;
            3'd4:    val = 16'd6272;
            3'd5:    val = 16'd7040;
            3'd6:    val = 16'd7902;
            default: val = 16'd0;
        endcase
        return val;
    endfunction

endpackage

// ----- rtl/fnq_calc.sv -----
`timescale 1ns / 1ps

module fnq_calc
(
    input  logic [fnq_pkg::FREQ_W-1:0] freq,
    output fnq_pkg::result_t           result
);

    logic [fnq_pkg::FREQ_W-1:0]   f;
    logic [fnq_pkg::FREQ_W-1:0]   v;
    logic [1:0]                   shift;
    logic                         too_high;
    logic                         too_low;
    logic [fnq_pkg::NOTE_W-1:0]   note;
    logic [fnq_pkg::FREQ_W-1:0]   table_freq;

    assign f        = freq + fnq_pkg::FREQ_W'(1);
    assign too_high = (f == '0) || (f >= fnq_pkg::BASE_FREQ);

    always_comb
    begin
        too_low = 1'b0;
        if ((f << 1) >= fnq_pkg::BASE_FREQ)
        begin
            shift = 2'd1;
        end
        else if ((f << 2) >= fnq_pkg::BASE_FREQ)
        begin
            shift = 2'd2;
        end
        else if ((f << 3) >= fnq_pkg::BASE_FREQ)
        begin
            shift = 2'd3;
        end
        else
        begin
            shift   = 2'd3;
            too_low = 1'b1;
        end
    end

    assign v = f << shift;

    always_comb
    begin
        note = '0;
        for (int k = 1; k < fnq_pkg::NOTES; k++)
        begin
            if (v > fnq_pkg::note_freq(fnq_pkg::NOTE_W'(k)))
            begin
                note = note + fnq_pkg::NOTE_W'(1);
            end
        end
    end

    assign table_freq = fnq_pkg::note_freq(note) >> shift;

    always_comb
    begin
        result = '0;
        if (too_high)
        begin
            result.status = fnq_pkg::ST_TOO_HIGH;
        end
        else if (too_low)
        begin
            result.status = fnq_pkg::ST_TOO_LOW;
        end
        else
        begin
            result.status  = fnq_pkg::ST_IN_RANGE;
            result.note    = note;
            result.octave  = fnq_pkg::TOP_OCTAVE - fnq_pkg::OCTAVE_W'(shift);
            result.snapped = table_freq[fnq_pkg::SNAP_W-1:0];
        end
    end

endmodule

// ----- rtl/frequency_to_note_quantizer.sv -----
`timescale 1ns / 1ps

// Frequency to note quantizer.
// Input channel: freq_in with in_valid / in_stall. A beat moves at a rising
// edge with in_valid high and in_stall low.
// Output channel: range_status, note_index, octave_number, snapped_freq with
// out_valid / out_stall, same rule. One result beat per input beat, in order.
// Pipeline: an input register holds the accepted frequency; the quantizing
// logic sits between it and the result register. A result moves from the input
// register into the result register, which drives the output; while out_stall
// holds a full result register, the next result waits in the input register.
// Throughput: one beat per cycle while out_stall is low, set by the single
// pass through the threshold compares between the two registers.
// Stall: the result register holds while out_stall is high; the input
// register still takes a beat if it is empty, so in_stall rises only when
// both registers are full and the output is stalled.
// Reset: rst_n clears both valid flags; the block is empty and ready.
module frequency_to_note_quantizer
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [fnq_pkg::FREQ_W-1:0]    freq_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [fnq_pkg::STATUS_W-1:0]  range_status,
    output logic [fnq_pkg::NOTE_W-1:0]    note_index,
    output logic [fnq_pkg::OCTAVE_W-1:0]  octave_number,
    output logic [fnq_pkg::SNAP_W-1:0]    snapped_freq
);

    logic                         in_valid_reg;
    logic [fnq_pkg::FREQ_W-1:0]   freq_reg;
    logic                         res_valid_reg;
    fnq_pkg::result_t             res_reg;
    fnq_pkg::result_t             res_next;
    logic                         res_load;
    logic                         in_load;

    fnq_calc u_calc
    (
        .freq   (freq_reg),
        .result (res_next)
    );

    assign res_load = in_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !res_load;
    assign in_load  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (res_load)
            begin
                in_valid_reg <= 1'b0;
            end
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            freq_reg <= freq_in;
        end
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = res_valid_reg;
    assign range_status  = res_reg.status;
    assign note_index    = res_reg.note;
    assign octave_number = res_reg.octave;
    assign snapped_freq  = res_reg.snapped;

`ifndef ASSERT_OFF
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_valid_reg)
        else $error("accepted beat not held in input register");

    a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && out_stall |=> res_valid_reg && $stable(res_reg))
        else $error("stalled result changed or dropped");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && res_valid_reg && out_stall)
        else $error("input stalled while pipeline has room");

    a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.status != fnq_pkg::ST_IN_RANGE
        |-> res_reg.note == '0 && res_reg.octave == '0 && res_reg.snapped == '0)
        else $error("out-of-range result carries nonzero fields");

    a_octave_span: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.status == fnq_pkg::ST_IN_RANGE
        |-> res_reg.octave >= 3'd4 && res_reg.octave <= 3'd6)
        else $error("in-range octave outside 4 to 6");
`endif

endmodule
